// ===== hdl/ddm_pkg.sv =====
package ddm_pkg;

  // Input operation codes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MUL    = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_LEN_A = 1'b0,
    REG_LEN_B = 1'b1
  } reg_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_CALC = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // Quotient by ten of a value below 100: count the decade thresholds passed.
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [3:0] q;
    q = '0;
    for (int i = 1; i <= 9; i++) begin
      if (v >= 7'(i * 10)) begin
        q = q + 4'd1;
      end
    end
    return q;
  endfunction

endpackage

// ===== hdl/ddm_ram.sv =====
module ddm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/decimal_digit_multiplier_unit.sv =====
// Decimal digit multiplier: schoolbook product of two decimal operands.
//
// Input channel: a beat is taken at a clock edge with start high and busy
// low. in_operation selects a digit load into A or B (in_digit_index, 0 is
// the most significant position, in_digit_value clamped to 9) or a multiply.
// Code 3 and loads at an index of MAX_DIGITS or more are dropped.
// Configuration: cfg_we writes cfg_wdata into len_a (index 0) or len_b
// (index 1); write only while busy is low and no product digits are left.
// Result channel: out_valid marks each product digit for one cycle,
// most significant first, len_a + len_b clamped digits with leading zeros;
// out_last flags the least significant one. The receiver cannot stall.
// A load leaves busy low. After its accepting edge a multiply does
// digit-serial work, then one digit leaves per cycle, the first in the
// cycle after the emit phase starts. Each digit product has a read state
// that reads the partial-product RAM (registered read port) and forms the
// digit product, then a state to add, split by ten and write back; each
// row then has a further state to store its carry.
// Reset: len_a and len_b return to 1, the sequencer to idle, no strobe.
// Digit stores hold garbage until loaded; the product RAM needs no clearing.
module decimal_digit_multiplier_unit #(
  parameter int MAX_DIGITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [3:0] in_digit_index,
  input  logic [3:0] in_digit_value,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  output logic       out_valid,
  output logic [3:0] out_product_digit,
  output logic       out_last
);

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam int PD = 2 * MAX_DIGITS;
  localparam int PW = $clog2(PD);
  localparam int TW = $clog2(PD + 1);

  ddm_pkg::state_t state_r, state_nxt;

  logic [4:0]    len_a_r, len_b_r;
  logic [3:0]    digits_a_r [MAX_DIGITS];
  logic [3:0]    digits_b_r [MAX_DIGITS];

  logic [LW-1:0] la_r, la_nxt, lb_r, lb_nxt;
  logic [LW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic [3:0]    carry_r, carry_nxt;
  logic [6:0]    prod_r, prod_nxt;
  logic          valid_r, valid_nxt;
  logic          last_r, last_nxt;

  logic          accept;
  logic          load_ok;
  logic [3:0]    load_val;
  logic [IW-1:0] load_idx;
  logic [LW-1:0] la_cl, lb_cl;
  logic [IW-1:0] a_idx, b_idx;
  logic [3:0]    partial;
  logic [6:0]    sum;
  logic [3:0]    quo, rem;
  logic [TW-1:0] total, emit_addr;

  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [3:0]    ram_wdata, ram_rdata;

  assign busy     = (state_r != ddm_pkg::ST_IDLE);
  assign accept   = start & ~busy;
  assign load_ok  = int'(in_digit_index) < MAX_DIGITS;
  assign load_val = (in_digit_value > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : in_digit_value;
  assign load_idx = IW'(in_digit_index);

  // Clamp lengths into 1..MAX_DIGITS.
  assign la_cl = (len_a_r == 5'd0) ? LW'(1) :
                 (int'(len_a_r) > MAX_DIGITS) ? LW'(MAX_DIGITS) : LW'(len_a_r);
  assign lb_cl = (len_b_r == 5'd0) ? LW'(1) :
                 (int'(len_b_r) > MAX_DIGITS) ? LW'(MAX_DIGITS) : LW'(len_b_r);

  // Digits are walked from the least significant end.
  assign a_idx = IW'(la_r - LW'(1) - r_r);
  assign b_idx = IW'(lb_r - LW'(1) - c_r);

  // Row zero sees a cleared product store; stale RAM content is ignored.
  assign partial = (r_r == '0) ? 4'd0 : ram_rdata;
  assign sum     = prod_r + 7'(partial) + 7'(carry_r);
  assign quo     = ddm_pkg::div10(sum);
  assign rem     = 4'(sum - 7'({quo, 3'b000}) - 7'({quo, 1'b0}));

  assign total     = TW'(la_r) + TW'(lb_r);
  assign emit_addr = total - TW'(1) - k_r;

  always_comb begin
    state_nxt = state_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    carry_nxt = carry_r;
    prod_nxt  = prod_r;
    valid_nxt = 1'b0;
    last_nxt  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = PW'(r_r) + PW'(c_r);
    ram_wdata = rem;
    ram_raddr = PW'(r_r) + PW'(c_r);
    unique case (state_r)
      ddm_pkg::ST_IDLE: begin
        if (accept && in_operation == ddm_pkg::OP_MUL) begin
          la_nxt    = la_cl;
          lb_nxt    = lb_cl;
          r_nxt     = '0;
          c_nxt     = '0;
          carry_nxt = '0;
          state_nxt = ddm_pkg::ST_RD;
        end
      end
      ddm_pkg::ST_RD: begin
        // Fetch the running digit and form the digit product.
        prod_nxt  = 7'(digits_a_r[a_idx]) * 7'(digits_b_r[b_idx]);
        state_nxt = ddm_pkg::ST_CALC;
      end
      ddm_pkg::ST_CALC: begin
        ram_we    = 1'b1;
        carry_nxt = quo;
        if (c_r == lb_r - LW'(1)) begin
          state_nxt = ddm_pkg::ST_FIN;
        end else begin
          c_nxt     = c_r + LW'(1);
          state_nxt = ddm_pkg::ST_RD;
        end
      end
      ddm_pkg::ST_FIN: begin
        // Top position of this row is still fresh: store the carry as is.
        ram_we    = 1'b1;
        ram_waddr = PW'(r_r) + PW'(lb_r);
        ram_wdata = carry_r;
        carry_nxt = '0;
        c_nxt     = '0;
        if (r_r == la_r - LW'(1)) begin
          k_nxt     = '0;
          state_nxt = ddm_pkg::ST_EMIT;
        end else begin
          r_nxt     = r_r + LW'(1);
          state_nxt = ddm_pkg::ST_RD;
        end
      end
      ddm_pkg::ST_EMIT: begin
        // Read one digit per cycle; it shows on the outputs in the next cycle.
        ram_raddr = emit_addr[PW-1:0];
        valid_nxt = 1'b1;
        last_nxt  = (k_r == total - TW'(1));
        k_nxt     = k_r + TW'(1);
        if (k_r == total - TW'(1)) begin
          state_nxt = ddm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ddm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddm_pkg::ST_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      len_a_r <= 5'd1;
      len_b_r <= 5'd1;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ddm_pkg::REG_LEN_A: len_a_r <= cfg_wdata;
          ddm_pkg::REG_LEN_B: len_b_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    la_r    <= la_nxt;
    lb_r    <= lb_nxt;
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    k_r     <= k_nxt;
    carry_r <= carry_nxt;
    prod_r  <= prod_nxt;
    if (accept && load_ok) begin
      unique case (in_operation)
        ddm_pkg::OP_LOAD_A: digits_a_r[load_idx] <= load_val;
        ddm_pkg::OP_LOAD_B: digits_b_r[load_idx] <= load_val;
        default: ;
      endcase
    end
  end

  ddm_ram #(
    .WIDTH(4),
    .DEPTH(PD)
  ) u_prod_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid         = valid_r;
  assign out_product_digit = ram_rdata;
  assign out_last          = last_r;

endmodule
